FILE: design/prc_pkg.sv
// ----------------------------------------------------------------------------
// prc_pkg
// Shared constants, types and sequencer states of the rectangle clipper.
// ----------------------------------------------------------------------------
package prc_pkg;

  localparam int MAX_VERTICES = 32;
  localparam int COORD_W      = 32;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int HALF_W       = 31;
  localparam int PROD_W       = 2 * COORD_W;
  localparam int EXT_W        = COORD_W + 2;
  localparam int DIV_STEP_W   = $clog2(PROD_W);

  // configuration register indexes
  localparam logic REG_HALF_WIDTH  = 1'b0;
  localparam logic REG_HALF_HEIGHT = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic        [CNT_W-1:0]   cnt_t;
  typedef logic        [ADDR_W-1:0]  addr_t;

  typedef struct packed {
    coord_t y;
    coord_t x;
  } vtx_t;

  typedef struct packed {
    logic                  start;
    logic [PROD_W-1:0]     dividend;
    logic [COORD_W-1:0]    divisor;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [PROD_W-1:0]     quotient;
  } div_rsp_t;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_RD_FIRST,
    ST_WAIT_FIRST,
    ST_RD_NEXT,
    ST_WAIT_NEXT,
    ST_EDGE,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_PUSH_X,
    ST_PUSH_V2,
    ST_ADVANCE,
    ST_PASS_END,
    ST_OUT_START,
    ST_OUT_RD,
    ST_OUT_WAIT,
    ST_OUT_SHOW
  } state_t;

endpackage

FILE: design/prc_if.sv
// ----------------------------------------------------------------------------
// prc_vtx_if / prc_clip_if
// Valid/ready channels for input vertices and clipped result vertices.
// ----------------------------------------------------------------------------
interface prc_vtx_if;
  import prc_pkg::*;
  logic   valid;
  logic   ready;
  coord_t vertex_x;
  coord_t vertex_y;
  logic   vertex_last;
  modport source (output valid, vertex_x, vertex_y, vertex_last, input ready);
  modport sink   (input valid, vertex_x, vertex_y, vertex_last, output ready);
endinterface

interface prc_clip_if;
  import prc_pkg::*;
  logic   valid;
  logic   ready;
  coord_t clip_x;
  coord_t clip_y;
  logic   clip_last;
  cnt_t   clip_count;
  logic   clip_empty;
  logic   clip_overflow;
  modport source (output valid, clip_x, clip_y, clip_last, clip_count, clip_empty,
                  clip_overflow, input ready);
  modport sink   (input valid, clip_x, clip_y, clip_last, clip_count, clip_empty,
                  clip_overflow, output ready);
endinterface

FILE: design/prc_ram.sv
// ----------------------------------------------------------------------------
// prc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module prc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/prc_div.sv
// ----------------------------------------------------------------------------
// prc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module prc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  prc_pkg::div_req_t req,
  output prc_pkg::div_rsp_t rsp
);
  import prc_pkg::*;

  logic                  busy_r;
  logic                  done_r;
  logic [DIV_STEP_W-1:0] step_r;
  logic [COORD_W-1:0]    rem_r;
  logic [PROD_W-1:0]     dvd_r;
  logic [COORD_W-1:0]    den_r;
  logic [COORD_W:0]      trial;
  logic                  ge;

  assign trial = {rem_r, dvd_r[PROD_W-1]};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == DIV_STEP_W'(PROD_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      dvd_r <= req.dividend;
      den_r <= req.divisor;
    end else if (busy_r) begin
      // remainder stays below the divisor, so it fits the low bits
      rem_r <= ge ? COORD_W'(trial - {1'b0, den_r}) : trial[COORD_W-1:0];
      dvd_r <= {dvd_r[PROD_W-2:0], ge};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = dvd_r;

endmodule

FILE: design/polygon_rectangle_clipper.sv
// ----------------------------------------------------------------------------
// polygon_rectangle_clipper
// Sutherland-Hodgman clipping of a closed polygon against a centered rectangle.
// ----------------------------------------------------------------------------
// Vertices (signed Q16.16) load one per cycle into buffer A until a vertex
// marked last; loading stalls the input for the whole clip and output phase.
// The polygon is then clipped in four passes (x >= -W, x <= W, y <= H,
// y >= -H) that ping-pong between two 32-entry RAMs. Each pass sets up in
// RD_FIRST and WAIT_FIRST and wraps up in PASS_END; per edge it reads the
// next vertex through the RAM latency (RD_NEXT, WAIT_NEXT), classifies the
// edge (EDGE), advances (ADVANCE) and takes one PUSH state per vertex
// written. An edge that crosses the bound adds a 32x32 multiply, a divider
// start and a 64-step restoring divide; the closing edge reuses the first
// vertex and skips the RAM wait. Results are then read out of buffer A
// through OUT_RD, OUT_WAIT and OUT_SHOW, one transfer at a time, each
// offered until the sink is ready. More than 32 vertices in the load or in
// a pass are dropped and reported through clip_overflow; an empty result is
// a single transfer with clip_empty set.
// ----------------------------------------------------------------------------
module polygon_rectangle_clipper (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [prc_pkg::HALF_W-1:0] cfg_data,
  prc_vtx_if.sink                 in_vtx,
  prc_clip_if.source              out_clip
);
  import prc_pkg::*;

  state_t state_r, state_nxt;

  logic [HALF_W-1:0] half_w_r, half_h_r;
  cnt_t  load_cnt_r, n_r, cnt_r, k_r, idx_r;
  logic  ovf_r;
  logic [1:0] pass_r;
  vtx_t  v1_r, v2_r, first_r, cross_r;
  logic  in2_r, neg_r;
  logic [COORD_W-1:0] mag_n_r, mag_o_r, mag_a_r;
  logic [PROD_W-1:0]  prod_r;

  // output payload registers
  coord_t out_x_r, out_y_r;
  logic   out_last_r, out_empty_r;

  // RAM ports
  logic  a_we, b_we;
  addr_t wr_addr, rd_addr;
  vtx_t  a_wdata, b_wdata, a_rdata, b_rdata, rd_vtx, push_vtx;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic in_xfer, out_xfer, pushing, room;

  assign in_xfer  = in_vtx.valid && in_vtx.ready;
  assign out_xfer = out_clip.valid && out_clip.ready;
  assign room     = cnt_r < cnt_t'(MAX_VERTICES);

  // ---------------------------------------------------------------------------
  // Edge geometry: the axis and bound follow the pass number.
  // ---------------------------------------------------------------------------
  logic on_y, upper;
  logic signed [EXT_W-1:0] bound, a1, a2, o1, o2, d_n, d_o, d_a;
  logic in1, in2;

  assign on_y  = pass_r[1];
  assign upper = pass_r[1] ^ pass_r[0];

  always_comb begin
    unique case (pass_r)
      2'd0:    bound = -$signed({3'b000, half_w_r});
      2'd1:    bound =  $signed({3'b000, half_w_r});
      2'd2:    bound =  $signed({3'b000, half_h_r});
      default: bound = -$signed({3'b000, half_h_r});
    endcase
  end

  assign a1  = EXT_W'(on_y ? v1_r.y : v1_r.x);
  assign a2  = EXT_W'(on_y ? v2_r.y : v2_r.x);
  assign o1  = EXT_W'(on_y ? v1_r.x : v1_r.y);
  assign o2  = EXT_W'(on_y ? v2_r.x : v2_r.y);
  assign d_n = bound - a1;
  assign d_o = o2 - o1;
  assign d_a = a2 - a1;
  assign in1 = upper ? (a1 <= bound) : (a1 >= bound);
  assign in2 = upper ? (a2 <= bound) : (a2 >= bound);

  // all magnitudes stay below 2^32
  function automatic logic [COORD_W-1:0] mag(input logic signed [EXT_W-1:0] v);
    logic signed [EXT_W-1:0] m;
    m = v[EXT_W-1] ? -v : v;
    return m[COORD_W-1:0];
  endfunction

  // crossing along the other axis: v1.other +/- |n*dO|/|dA|
  logic signed [COORD_W-1:0] v1_other, cross_o;
  logic [COORD_W-1:0] q_lo;
  assign v1_other = on_y ? v1_r.x : v1_r.y;
  assign q_lo     = div_rsp.quotient[COORD_W-1:0];
  assign cross_o  = neg_r ? v1_other - $signed(q_lo) : v1_other + $signed(q_lo);

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD:       if (in_xfer && in_vtx.vertex_last) state_nxt = ST_RD_FIRST;
      ST_RD_FIRST:   state_nxt = (n_r == '0) ? ST_PASS_END : ST_WAIT_FIRST;
      ST_WAIT_FIRST: state_nxt = ST_RD_NEXT;
      ST_RD_NEXT:    state_nxt = (k_r == n_r) ? ST_EDGE : ST_WAIT_NEXT;
      ST_WAIT_NEXT:  state_nxt = ST_EDGE;
      ST_EDGE: begin
        priority if (in1 && in2) state_nxt = ST_PUSH_V2;
        else if (in1 || in2)     state_nxt = ST_MUL;
        else                     state_nxt = ST_ADVANCE;
      end
      ST_MUL:        state_nxt = ST_DIV_GO;
      ST_DIV_GO:     state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT:   if (div_rsp.done) state_nxt = ST_PUSH_X;
      ST_PUSH_X:     state_nxt = in2_r ? ST_PUSH_V2 : ST_ADVANCE;
      ST_PUSH_V2:    state_nxt = ST_ADVANCE;
      ST_ADVANCE:    state_nxt = (k_r == n_r) ? ST_PASS_END : ST_RD_NEXT;
      ST_PASS_END:   state_nxt = (pass_r == 2'd3) ? ST_OUT_START : ST_RD_FIRST;
      ST_OUT_START:  state_nxt = (n_r == '0) ? ST_OUT_SHOW : ST_OUT_RD;
      ST_OUT_RD:     state_nxt = ST_OUT_WAIT;
      ST_OUT_WAIT:   state_nxt = ST_OUT_SHOW;
      ST_OUT_SHOW: begin
        if (out_xfer) state_nxt = out_last_r ? ST_LOAD : ST_OUT_RD;
      end
      default:       state_nxt = ST_LOAD;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control outputs: RAM ports, handshakes, divider start
  // ---------------------------------------------------------------------------
  always_comb begin
    in_vtx.ready   = 1'b0;
    out_clip.valid = 1'b0;
    pushing        = 1'b0;
    rd_addr        = '0;
    push_vtx       = v2_r;
    div_req.start  = 1'b0;
    unique case (state_r)
      ST_LOAD:     in_vtx.ready   = 1'b1;
      ST_RD_NEXT:  rd_addr        = k_r[ADDR_W-1:0];
      ST_DIV_GO:   div_req.start  = 1'b1;
      ST_PUSH_X: begin
        pushing  = 1'b1;
        push_vtx = cross_r;
      end
      ST_PUSH_V2:  pushing        = 1'b1;
      ST_OUT_RD:   rd_addr        = idx_r[ADDR_W-1:0];
      ST_OUT_SHOW: out_clip.valid = 1'b1;
      default: ;
    endcase
  end

  assign div_req.dividend = prod_r;
  assign div_req.divisor  = mag_a_r;

  // even passes read A and write B, odd passes the reverse
  assign rd_vtx  = pass_r[0] ? b_rdata : a_rdata;
  assign wr_addr = (state_r == ST_LOAD) ? load_cnt_r[ADDR_W-1:0] : cnt_r[ADDR_W-1:0];
  assign a_we    = (in_xfer && load_cnt_r < cnt_t'(MAX_VERTICES))
                   || (pushing && room && pass_r[0]);
  assign b_we    = pushing && room && !pass_r[0];
  assign a_wdata = (state_r == ST_LOAD) ? vtx_t'{y: in_vtx.vertex_y, x: in_vtx.vertex_x}
                                        : push_vtx;
  assign b_wdata = push_vtx;

  prc_ram #(.WIDTH($bits(vtx_t)), .DEPTH(MAX_VERTICES)) u_buf_a (
    .clk, .we(a_we), .waddr(wr_addr), .wdata(a_wdata), .raddr(rd_addr), .rdata(a_rdata)
  );

  prc_ram #(.WIDTH($bits(vtx_t)), .DEPTH(MAX_VERTICES)) u_buf_b (
    .clk, .we(b_we), .waddr(wr_addr), .wdata(b_wdata), .raddr(rd_addr), .rdata(b_rdata)
  );

  prc_div u_div (.clk, .rst_n, .req(div_req), .rsp(div_rsp));

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      half_w_r   <= HALF_W'(65536);
      half_h_r   <= HALF_W'(65536);
      load_cnt_r <= '0;
      ovf_r      <= 1'b0;
      pass_r     <= '0;
      cnt_r      <= '0;
      n_r        <= '0;
      k_r        <= '0;
      idx_r      <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_HALF_WIDTH:  half_w_r <= cfg_data;
          REG_HALF_HEIGHT: half_h_r <= cfg_data;
        endcase
      end
      unique case (state_r)
        ST_LOAD: begin
          if (in_xfer) begin
            // hold at full depth and drop the rest
            if (load_cnt_r < cnt_t'(MAX_VERTICES)) begin
              load_cnt_r <= load_cnt_r + 1'b1;
            end else begin
              ovf_r <= 1'b1;
            end
            if (in_vtx.vertex_last) begin
              n_r    <= (load_cnt_r < cnt_t'(MAX_VERTICES)) ? load_cnt_r + 1'b1 : load_cnt_r;
              pass_r <= '0;
              cnt_r  <= '0;
            end
          end
        end
        ST_WAIT_FIRST: k_r <= cnt_t'(1);
        ST_PUSH_X, ST_PUSH_V2: begin
          if (room) begin
            cnt_r <= cnt_r + 1'b1;
          end else begin
            ovf_r <= 1'b1;
          end
        end
        ST_ADVANCE: if (k_r != n_r) k_r <= k_r + 1'b1;
        ST_PASS_END: begin
          n_r    <= cnt_r;
          cnt_r  <= '0;
          pass_r <= pass_r + 1'b1;
        end
        ST_OUT_START: idx_r <= '0;
        ST_OUT_SHOW: begin
          if (out_xfer) begin
            if (out_last_r) begin
              load_cnt_r <= '0;
              ovf_r      <= 1'b0;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_WAIT_FIRST: begin
        v1_r    <= rd_vtx;
        first_r <= rd_vtx;
      end
      ST_RD_NEXT:   if (k_r == n_r) v2_r <= first_r;
      ST_WAIT_NEXT: v2_r <= rd_vtx;
      ST_EDGE: begin
        in2_r   <= in2;
        neg_r   <= d_n[EXT_W-1] ^ d_o[EXT_W-1] ^ d_a[EXT_W-1];
        mag_n_r <= mag(d_n);
        mag_o_r <= mag(d_o);
        mag_a_r <= mag(d_a);
      end
      ST_MUL: prod_r <= mag_n_r * mag_o_r;
      ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          cross_r.x <= on_y ? cross_o : bound[COORD_W-1:0];
          cross_r.y <= on_y ? bound[COORD_W-1:0] : cross_o;
        end
      end
      ST_ADVANCE: v1_r <= v2_r;
      ST_OUT_START: begin
        if (n_r == '0) begin
          out_x_r     <= '0;
          out_y_r     <= '0;
          out_last_r  <= 1'b1;
          out_empty_r <= 1'b1;
        end
      end
      ST_OUT_WAIT: begin
        out_x_r     <= a_rdata.x;
        out_y_r     <= a_rdata.y;
        out_last_r  <= (idx_r + 1'b1) == n_r;
        out_empty_r <= 1'b0;
      end
      default: ;
    endcase
  end

  assign out_clip.clip_x        = out_x_r;
  assign out_clip.clip_y        = out_y_r;
  assign out_clip.clip_last     = out_last_r;
  assign out_clip.clip_count    = n_r;
  assign out_clip.clip_empty    = out_empty_r;
  assign out_clip.clip_overflow = ovf_r;

`ifndef ASSERT_OFF
  // a pass never writes beyond the buffer depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cnt_t'(MAX_VERTICES))
    else $error("pass count beyond buffer depth");

  // the input stays stalled while results are offered
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_clip.valid |-> !in_vtx.ready)
    else $error("input accepted during output");

  // an empty result reports zero vertices and ends the polygon
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_clip.valid && out_clip.clip_empty) |->
      (out_clip.clip_count == '0 && out_clip.clip_last))
    else $error("empty result inconsistent");

  // a quotient is only taken while waiting on the divider
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == ST_DIV_WAIT)
    else $error("divider finished outside its wait state");
`endif

endmodule

FILE: verif/polygon_rectangle_clipper_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_rectangle_clipper_tb
// Feeds polygons to the rectangle clipper under several half-size settings
// and idle patterns, predicts every clipped vertex and compares each result
// transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module polygon_rectangle_clipper_tb;
  import prc_pkg::*;

  localparam int  WATCHDOG_LIMIT = 60000;
  localparam int  LONG_HOLD      = 700;
  localparam int  SETTLE_CYCLES  = 40;
  localparam longint COORD_MIN   = -64'sd2147483648;
  localparam longint COORD_MAX   = 64'sd2147483647;

  typedef enum int {GEN_NEAR, GEN_FULL, GEN_EDGE} gen_mode_t;

  typedef struct {
    coord_t x;
    coord_t y;
    logic   last;
  } vertex_item_t;

  typedef struct {
    coord_t x;
    coord_t y;
    logic   last;
    cnt_t   count;
    logic   empty;
    logic   overflow;
  } clip_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [HALF_W-1:0] cfg_data;

  prc_vtx_if  vtx ();
  prc_clip_if clp ();

  polygon_rectangle_clipper dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_vtx    (vtx.sink),
    .out_clip  (clp.source)
  );

  // stimulus and prediction state
  vertex_item_t pending_vertices[$];
  clip_result_t expected_clips[$];
  longint       loaded_x[$];
  longint       loaded_y[$];
  bit           load_dropped;
  bit           pass_dropped;
  longint       model_half_w;
  longint       model_half_h;
  int           src_idle_pct;
  int           snk_stall_pct;
  bit           hold_req;
  bit           hold_done;
  int           hold_cnt;
  int           quiet_cycles;
  int           error_count;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Predictor: crossing point and one Sutherland-Hodgman pass on 64-bit coords
  // ---------------------------------------------------------------------------
  function automatic longint crossing(input longint b, input longint a1, input longint o1,
                                      input longint da, input longint dd);
    longint    n;
    bit [63:0] mn;
    bit [63:0] md;
    bit [63:0] den;
    bit [63:0] q;
    bit        neg;
    n   = b - a1;
    den = (da < 0) ? -da : da;
    if (den == 0) return o1;
    mn  = (n < 0) ? -n : n;
    md  = (dd < 0) ? -dd : dd;
    q   = (mn * md) / den;
    neg = ((n < 0) != (dd < 0)) != (da < 0);
    if (n == 0 || dd == 0) neg = 1'b0;
    return neg ? o1 - longint'(q) : o1 + longint'(q);
  endfunction

  function automatic void keep_vertex(ref longint xs[$], ref longint ys[$],
                                      input longint x, input longint y);
    if (xs.size() < MAX_VERTICES) begin
      xs.insert(xs.size(), x);
      ys.insert(ys.size(), y);
    end else begin
      pass_dropped = 1'b1;
    end
  endfunction

  function automatic void clip_against(ref longint xs[$], ref longint ys[$],
                                       input bit on_y, input bit upper, input longint b);
    longint ox[$];
    longint oy[$];
    int     n;
    int     j;
    longint a1, a2, cx, cy;
    bit     in1, in2;
    n = xs.size();
    for (int i = 0; i < n; i++) begin
      j   = (i + 1 == n) ? 0 : i + 1;
      a1  = on_y ? ys[i] : xs[i];
      a2  = on_y ? ys[j] : xs[j];
      in1 = upper ? (a1 <= b) : (a1 >= b);
      in2 = upper ? (a2 <= b) : (a2 >= b);
      if (on_y) begin
        cy = b;
        cx = crossing(b, ys[i], xs[i], ys[j] - ys[i], xs[j] - xs[i]);
      end else begin
        cx = b;
        cy = crossing(b, xs[i], ys[i], xs[j] - xs[i], ys[j] - ys[i]);
      end
      if (in1 && in2) begin
        keep_vertex(ox, oy, xs[j], ys[j]);
      end else if (in1) begin
        keep_vertex(ox, oy, cx, cy);
      end else if (in2) begin
        keep_vertex(ox, oy, cx, cy);
        keep_vertex(ox, oy, xs[j], ys[j]);
      end
    end
    xs = ox;
    ys = oy;
  endfunction

  // Take one accepted vertex; on the last one clip and queue the results.
  function automatic void predict_vertex(input vertex_item_t v);
    clip_result_t r;
    int           n;
    bit           ovf;
    if (loaded_x.size() < MAX_VERTICES) begin
      loaded_x.insert(loaded_x.size(), longint'(v.x));
      loaded_y.insert(loaded_y.size(), longint'(v.y));
    end else begin
      load_dropped = 1'b1;
    end
    if (!v.last) return;
    pass_dropped = 1'b0;
    clip_against(loaded_x, loaded_y, 1'b0, 1'b0, -model_half_w);
    clip_against(loaded_x, loaded_y, 1'b0, 1'b1,  model_half_w);
    clip_against(loaded_x, loaded_y, 1'b1, 1'b1,  model_half_h);
    clip_against(loaded_x, loaded_y, 1'b1, 1'b0, -model_half_h);
    ovf = load_dropped | pass_dropped;
    n   = loaded_x.size();
    if (n == 0) begin
      r = '{x: '0, y: '0, last: 1'b1, count: '0, empty: 1'b1, overflow: ovf};
      expected_clips.insert(expected_clips.size(), r);
    end
    for (int k = 0; k < n; k++) begin
      r.x        = coord_t'(loaded_x[k][COORD_W-1:0]);
      r.y        = coord_t'(loaded_y[k][COORD_W-1:0]);
      r.last     = (k + 1 == n);
      r.count    = cnt_t'(n);
      r.empty    = 1'b0;
      r.overflow = ovf;
      expected_clips.insert(expected_clips.size(), r);
    end
    loaded_x.delete();
    loaded_y.delete();
    load_dropped = 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offer the head of the pending queue, hold it until the transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    bit offer;
    if (!rst_n) begin
      vtx.valid <= 1'b0;
    end else begin
      if (vtx.valid && vtx.ready) begin
        predict_vertex(pending_vertices.pop_front());
        quiet_cycles = 0;
      end
      if (vtx.valid && !vtx.ready) begin
        offer = 1'b1;   // hold the item already on the bus
      end else begin
        offer = (pending_vertices.size() > 0) && ($urandom_range(99) >= src_idle_pct);
      end
      vtx.valid <= offer;
      if (offer) begin
        vtx.vertex_x    <= pending_vertices[0].x;
        vtx.vertex_y    <= pending_vertices[0].y;
        vtx.vertex_last <= pending_vertices[0].last;
      end
    end
  end

  // Sink ready: random stalls, plus one long hold-off to back the block up.
  always @(posedge clk) begin
    if (!rst_n) begin
      clp.ready <= 1'b0;
      hold_cnt  = 0;
      hold_done = 1'b0;
    end else if (hold_req && !hold_done) begin
      clp.ready <= 1'b0;
      hold_cnt++;
      if (hold_cnt >= LONG_HOLD) hold_done = 1'b1;
    end else begin
      clp.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Monitor: compare every result transfer with the oldest prediction.
  always @(posedge clk) begin
    clip_result_t e;
    if (rst_n && clp.valid && clp.ready) begin
      quiet_cycles = 0;
      if (expected_clips.size() == 0) begin
        report_mismatch("unexpected result clip_x", clp.clip_x, 0);
      end else begin
        e = expected_clips.pop_front();
        if (clp.clip_x !== e.x) report_mismatch("clip_x", clp.clip_x, e.x);
        if (clp.clip_y !== e.y) report_mismatch("clip_y", clp.clip_y, e.y);
        if (clp.clip_last !== e.last) report_mismatch("clip_last", clp.clip_last, e.last);
        if (clp.clip_count !== e.count) report_mismatch("clip_count", clp.clip_count, e.count);
        if (clp.clip_empty !== e.empty) report_mismatch("clip_empty", clp.clip_empty, e.empty);
        if (clp.clip_overflow !== e.overflow)
          report_mismatch("clip_overflow", clp.clip_overflow, e.overflow);
      end
    end
  end

  // Watchdog: count cycles with no transfer on either channel.
  always @(posedge clk) begin
    if (rst_n && !(vtx.valid && vtx.ready) && !(clp.valid && clp.ready)) begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic coord_t clamp_coord(input longint v);
    if (v < COORD_MIN) return coord_t'(COORD_MIN);
    if (v > COORD_MAX) return coord_t'(COORD_MAX);
    return coord_t'(v);
  endfunction

  function automatic coord_t pick_coord(input longint half, input gen_mode_t mode);
    longint span;
    longint r;
    case (mode)
      GEN_FULL: begin
        return coord_t'($urandom);
      end
      GEN_EDGE: begin
        case ($urandom_range(5))
          0: return clamp_coord(half);
          1: return clamp_coord(-half);
          2: return clamp_coord(half + 1);
          3: return clamp_coord(-half - 1);
          4: return '0;
          default: return coord_t'($urandom);
        endcase
      end
      default: begin
        span = half * 3 + 16;
        r    = longint'({$urandom, $urandom} % (2 * span + 1)) - span;
        return clamp_coord(r);
      end
    endcase
  endfunction

  task automatic add_vertex(input coord_t x, input coord_t y, input logic last);
    vertex_item_t v;
    v = '{x: x, y: y, last: last};
    pending_vertices.insert(pending_vertices.size(), v);
  endtask

  task automatic add_random_polygon(input int nv, input gen_mode_t mode);
    gen_mode_t m;
    for (int i = 0; i < nv; i++) begin
      m = (mode == GEN_EDGE && $urandom_range(2) == 0) ? GEN_NEAR : mode;
      add_vertex(pick_coord(model_half_w, m), pick_coord(model_half_h, m), i == nv - 1);
    end
  endtask

  // Wait until every vertex is taken and every result has come, then settle.
  task automatic drain();
    wait (pending_vertices.size() == 0 && expected_clips.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input longint value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value[HALF_W-1:0];
    if (idx == REG_HALF_WIDTH) model_half_w = value & 64'h7FFF_FFFF;
    else model_half_h = value & 64'h7FFF_FFFF;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One phase: new half-sizes, an idle pattern, then random polygons.
  task automatic run_phase(input longint w, input longint h, input int src_pct,
                           input int snk_pct, input int n_items, input bit long_hold);
    int        sent;
    int        nv;
    int        pick;
    gen_mode_t mode;
    drain();
    write_reg(REG_HALF_WIDTH, w);
    write_reg(REG_HALF_HEIGHT, h);
    src_idle_pct  <= src_pct;
    snk_stall_pct <= snk_pct;
    if (long_hold) hold_req <= 1'b1;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 4) nv = 33 + $urandom_range(3);       // load overflow
      else if (pick < 9) nv = 24 + $urandom_range(8);  // long loops, pass overflow
      else if (pick < 14) nv = 1 + $urandom_range(1);
      else nv = 3 + $urandom_range(6);
      pick = $urandom_range(99);
      mode = (pick < 70) ? GEN_NEAR : (pick < 85) ? GEN_EDGE : GEN_FULL;
      add_random_polygon(nv, mode);
      sent += nv;
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = REG_HALF_WIDTH;
    cfg_data         = '0;
    vtx.valid        = 1'b0;
    vtx.vertex_x     = '0;
    vtx.vertex_y     = '0;
    vtx.vertex_last  = 1'b0;
    clp.ready        = 1'b0;
    model_half_w     = 65536;
    model_half_h     = 65536;
    load_dropped     = 1'b0;
    pass_dropped     = 1'b0;
    src_idle_pct     = 0;
    snk_stall_pct    = 0;
    hold_req         = 1'b0;
    quiet_cycles     = 0;
    error_count      = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset half-sizes of 1.0 in Q16.16.
    add_vertex(-32'sd16384, -32'sd16384, 1'b0);             // fully inside triangle
    add_vertex(32'sd16384, -32'sd16384, 1'b0);
    add_vertex(32'sd0, 32'sd16384, 1'b1);
    add_vertex(-32'sd131072, -32'sd131072, 1'b0);           // square around the box
    add_vertex(32'sd131072, -32'sd131072, 1'b0);
    add_vertex(32'sd131072, 32'sd131072, 1'b0);
    add_vertex(-32'sd131072, 32'sd131072, 1'b1);
    add_vertex(32'sd300000, 32'sd300000, 1'b0);             // fully outside: empty
    add_vertex(32'sd400000, 32'sd300000, 1'b0);
    add_vertex(32'sd400000, 32'sd500000, 1'b1);
    add_vertex(32'sd1000, -32'sd2000, 1'b1);                // single vertex inside
    add_vertex(-32'sd200000, 32'sd5, 1'b0);                 // two-vertex polygon
    add_vertex(32'sd200000, -32'sd7, 1'b1);
    add_vertex(32'h8000_0000, 32'h8000_0000, 1'b0);         // extreme corners
    add_vertex(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    add_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
    add_vertex(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    add_vertex(32'sd65536, 32'sd65536, 1'b0);               // vertices on the bounds
    add_vertex(-32'sd65536, 32'sd0, 1'b0);
    add_vertex(32'sd0, -32'sd65536, 1'b1);
    add_vertex(-32'sd70000, 32'sd12345, 1'b1);              // single vertex outside

    // Random phases over several half-sizes and idle patterns.
    run_phase(0, 0, 0, 0, 45, 1'b0);
    run_phase(64'h7FFF_FFFF, 64'h7FFF_FFFF, 0, 0, 45, 1'b1);
    run_phase(65536, 65536, 58, 0, 45, 1'b0);
    run_phase(longint'($urandom_range(32'h7FFF_FFFF)), longint'($urandom_range(32'h7FFF_FFFF)),
              0, 58, 45, 1'b0);
    run_phase(300, 64'h4000_0000, 15, 15, 45, 1'b0);
    run_phase(64'h0100_0000, 7, 0, 0, 45, 1'b0);
    run_phase(longint'($urandom_range(32'h0004_0000)), longint'($urandom_range(32'h0004_0000)),
              58, 58, 45, 1'b0);
    run_phase(131072, 40000, 15, 15, 45, 1'b0);

    drain();
    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
